// ----- hw/rtl/dtq_pkg.sv -----
package dtq_pkg;

  localparam int TIMER_COUNT_DEF = 16;
  localparam int SLOT_W = 4;
  localparam int TIME_W = 64;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // command codes
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_CANCEL  = 2'd1;
  localparam logic [1:0] CMD_EXPIRE  = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_EXPIRED = 2'd0;
  localparam logic [1:0] KIND_ARM     = 2'd1;
  localparam logic [1:0] KIND_CANCEL  = 2'd2;

  // one queue entry held by a cell
  typedef struct packed {
    logic              v;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] dl;
  } entry_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_MARK,
    OP_BUBBLE,
    OP_INSERT,
    OP_POP
  } cell_op_t;

  // control word broadcast to every cell
  typedef struct packed {
    cell_op_t          op;
    logic [SLOT_W-1:0] key_slot;
    logic [TIME_W-1:0] key_dl;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/deadline_timer_queue.sv -----
// Timer queue kept in a row of cells, head at cell 0, in expiry order (ties first-in
// first-out). Start of a timer that is already queued marks it and lets the hole left
// by its removal walk down the row before the new insert. Cancel replies in the cycle
// after the command and then stays busy only while it removes a queued timer. An
// expire pass pops every due timer from the head. Restart moves a deadline that is not
// later than now forward with the one-bit-per-cycle remainder unit. Results appear for
// one cycle each on strobe and cannot be held off; last marks the final word of a command.
module deadline_timer_queue
  import dtq_pkg::*;
#(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd,
  input  logic [SLOT_W-1:0] timer_id,
  input  logic [TIME_W-1:0] time_ns,
  input  logic [TIME_W-1:0] period_ns,
  output logic              strobe,
  output logic [1:0]        result_kind,
  output logic [SLOT_W-1:0] slot,
  output logic [TIME_W-1:0] deadline,
  output logic              cancel_hit,
  output logic              last
);

  localparam int IDX_W = $clog2(TIMER_COUNT);
  localparam int IW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MARK, S_COMPACT, S_INSERT, S_REARM, S_EXPIRE, S_READ, S_DIVIDE
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] id_q;
  logic [TIME_W-1:0] t_q;
  logic [TIME_W-1:0] iv_q;
  logic [TIME_W-1:0] key_q;
  logic [TIME_W-1:0] armed;
  logic [IDX_W-1:0]  cnt;
  logic              ins_pend;
  logic              q_wrap;
  logic [TIMER_COUNT-1:0] queued;
  logic [TIMER_COUNT-1:0] dl_set;
  logic              dl_set_rd;

  entry_t    ent [TIMER_COUNT];
  logic      aft [TIMER_COUNT];
  cell_ctl_t ctl;

  logic              accept;
  logic [IW-1:0]     id_ext;
  logic [IDX_W-1:0]  id_idx;
  logic              id_ok;
  logic [IW-1:0]     idq_ext;
  logic [IDX_W-1:0]  idq_idx;
  logic [IW-1:0]     hs_ext;
  logic [IDX_W-1:0]  hs_idx;
  entry_t            head;
  entry_t            nxt;
  logic              due;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [TIME_W-1:0] ram_wdata;
  logic [TIME_W-1:0] ram_rdata;
  logic [TIME_W-1:0] dl_rd;

  logic              div_go;
  logic [TIME_W-1:0] div_rem;
  logic              div_done;
  logic [TIME_W:0]   fwd_sum;
  logic [TIME_W-1:0] fwd;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // slot numbers as store indexes
  assign id_ext  = IW'(timer_id);
  assign id_idx  = id_ext[IDX_W-1:0];
  assign id_ok   = ({1'b0, id_ext} < (IW+1)'(TIMER_COUNT));
  assign idq_ext = IW'(id_q);
  assign idq_idx = idq_ext[IDX_W-1:0];
  assign head    = ent[0];
  assign nxt     = ent[1];
  assign hs_ext  = IW'(head.slot);
  assign hs_idx  = hs_ext[IDX_W-1:0];
  assign due     = head.v && (head.dl <= t_q);

  // drive the cell row
  always_comb begin
    ctl.key_slot = id_q;
    ctl.key_dl   = key_q;
    unique case (state)
      S_MARK:    ctl.op = OP_MARK;
      S_COMPACT: ctl.op = OP_BUBBLE;
      S_INSERT:  ctl.op = OP_INSERT;
      S_EXPIRE:  ctl.op = due ? OP_POP : OP_HOLD;
      default:   ctl.op = OP_HOLD;
    endcase
  end

  for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_cell
    entry_t l_ent;
    logic   l_aft;
    entry_t r_ent;
    if (i == 0) begin : g_first
      assign l_ent = '{v: 1'b1, slot: '0, dl: '0};
      assign l_aft = 1'b1;
    end else begin : g_mid
      assign l_ent = ent[i-1];
      assign l_aft = aft[i-1];
    end
    if (i == TIMER_COUNT - 1) begin : g_tail
      assign r_ent = '{v: 1'b0, slot: '0, dl: '0};
    end else begin : g_body
      assign r_ent = ent[i+1];
    end
    dtq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .left       (l_ent),
      .left_after (l_aft),
      .right      (r_ent),
      .ent        (ent[i]),
      .after      (aft[i])
    );
  end

  // per-slot deadlines; unwritten slots read as zero
  assign ram_we    = (accept && cmd == CMD_START && id_ok) || (state == S_DIVIDE && div_done);
  assign ram_waddr = (state == S_DIVIDE) ? idq_idx : id_idx;
  assign ram_wdata = (state == S_DIVIDE) ? fwd : time_ns;
  assign dl_rd     = dl_set_rd ? ram_rdata : '0;

  dtq_ram #(
    .WIDTH (TIME_W),
    .DEPTH (TIMER_COUNT)
  ) u_dl_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (id_idx),
    .rdata (ram_rdata)
  );

  // forward past now by whole intervals: now - rem + interval, saturated;
  // a step count of all ones plus one wraps to zero and keeps the old deadline
  assign div_go  = (state == S_READ) && (dl_rd <= t_q);
  assign fwd_sum = {1'b0, t_q} - {1'b0, div_rem} + {1'b0, iv_q};
  assign fwd     = q_wrap ? '0 : (fwd_sum[TIME_W] ? TIME_MAX : fwd_sum[TIME_W-1:0]);

  dtq_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (t_q - dl_rd),
    .divisor  (iv_q),
    .rem      (div_rem),
    .done     (div_done)
  );

  // sequence commands and register results
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      armed     <= TIME_MAX;
      queued    <= '0;
      dl_set    <= '0;
      strobe    <= 1'b0;
      dl_set_rd <= 1'b0;
    end else begin
      strobe    <= 1'b0;
      dl_set_rd <= dl_set[id_idx];
      if (ram_we) dl_set[ram_waddr] <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            id_q  <= timer_id;
            t_q   <= time_ns;
            iv_q  <= (period_ns == '0) ? TIME_W'(1) : period_ns;
            key_q <= time_ns;
            cnt   <= '0;
            unique case (cmd)
              CMD_START: begin
                if (id_ok) begin
                  ins_pend <= 1'b1;
                  state    <= queued[id_idx] ? S_MARK : S_INSERT;
                end
              end
              CMD_CANCEL: begin
                strobe      <= 1'b1;
                result_kind <= KIND_CANCEL;
                slot        <= timer_id;
                deadline    <= '0;
                cancel_hit  <= id_ok && queued[id_idx];
                last        <= 1'b1;
                ins_pend    <= 1'b0;
                if (id_ok && queued[id_idx]) state <= S_MARK;
              end
              CMD_EXPIRE: begin
                armed <= TIME_MAX;
                state <= S_EXPIRE;
              end
              CMD_RESTART: begin
                if (id_ok && !queued[id_idx]) state <= S_READ;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MARK: begin
          queued[idq_idx] <= 1'b0;
          state           <= S_COMPACT;
        end
        S_COMPACT: begin
          cnt <= cnt + 1'b1;
          if (cnt == IDX_W'(TIMER_COUNT - 2)) begin
            state <= ins_pend ? S_INSERT : S_IDLE;
          end
        end
        S_INSERT: begin
          queued[idq_idx] <= 1'b1;
          state           <= S_REARM;
        end
        S_REARM: begin
          if (head.dl < armed) begin
            armed       <= head.dl;
            strobe      <= 1'b1;
            result_kind <= KIND_ARM;
            slot        <= '0;
            deadline    <= head.dl;
            cancel_hit  <= 1'b0;
            last        <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_EXPIRE: begin
          if (due) begin
            queued[hs_idx] <= 1'b0;
            strobe         <= 1'b1;
            result_kind    <= KIND_EXPIRED;
            slot           <= head.slot;
            deadline       <= '0;
            cancel_hit     <= 1'b0;
            last           <= !(nxt.v && (nxt.dl <= t_q || nxt.dl != TIME_MAX));
          end else begin
            if (head.v && head.dl != TIME_MAX) begin
              armed       <= head.dl;
              strobe      <= 1'b1;
              result_kind <= KIND_ARM;
              slot        <= '0;
              deadline    <= head.dl;
              cancel_hit  <= 1'b0;
              last        <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_READ: begin
          q_wrap <= (dl_rd == '0) && (t_q == TIME_MAX) && (iv_q == TIME_W'(1));
          if (dl_rd > t_q) begin
            key_q <= dl_rd;
            state <= S_INSERT;
          end else begin
            state <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            key_q <= fwd;
            state <= S_INSERT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/dtq_ram.sv -----
module dtq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/dtq_rem.sv -----
module dtq_rem
  import dtq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [TIME_W-1:0] dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic [TIME_W-1:0] rem,
  output logic              done
);

  logic [TIME_W-1:0]         dvd;
  logic [TIME_W-1:0]         dvs;
  logic [$clog2(TIME_W)-1:0] cnt;
  logic                      run;
  logic [TIME_W:0]           r_sh;

  // shift in the next dividend bit
  assign r_sh = {rem, dvd[TIME_W-1]};

  // restoring division, one quotient bit per cycle, remainder only
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rem <= '0;
        dvd <= dividend;
        dvs <= divisor;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        dvd <= dvd << 1;
        if (r_sh >= {1'b0, dvs}) begin
          rem <= TIME_W'(r_sh - {1'b0, dvs});
        end else begin
          rem <= r_sh[TIME_W-1:0];
        end
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/dtq_cell.sv -----
module dtq_cell
  import dtq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  entry_t    left,
  input  logic      left_after,
  input  entry_t    right,
  output entry_t    ent,
  output logic      after
);

  entry_t ent_next;

  // new key goes behind this entry when this entry is due no later
  assign after = ent.v && (ent.dl <= ctl.key_dl);

  always_comb begin
    ent_next = ent;
    unique case (ctl.op)
      OP_HOLD: ent_next = ent;
      OP_MARK: begin
        if (ent.v && ent.slot == ctl.key_slot) ent_next.v = 1'b0;
      end
      // move a hole one place toward the tail
      OP_BUBBLE: begin
        if (!ent.v && right.v) begin
          ent_next = right;
        end else if (ent.v && !left.v) begin
          ent_next.v = 1'b0;
        end
      end
      OP_INSERT: begin
        if (after) begin
          ent_next = ent;
        end else if (left_after) begin
          ent_next.v    = 1'b1;
          ent_next.slot = ctl.key_slot;
          ent_next.dl   = ctl.key_dl;
        end else begin
          ent_next = left;
        end
      end
      OP_POP: ent_next = right;
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.v <= 1'b0;
    end else begin
      ent <= ent_next;
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import dtq_pkg::*;

  localparam int NT = 16;

  // one result word as the block reports it
  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] dl;
    logic              hit;
    logic              last;
  } word_t;

  // timer queue predictor with the pending result words
  class timer_scoreboard;
    logic [TIME_W-1:0] dl_of[NT];
    bit                queued[NT];
    int                order[$];
    logic [TIME_W-1:0] armed;
    word_t             pending[$];
    int                errors;

    function void clear();
      foreach (dl_of[i]) begin
        dl_of[i] = '0;
        queued[i] = 0;
      end
      order.delete();
      pending.delete();
      armed = TIME_MAX;
      errors = 0;
    endfunction

    function void unlink(int id);
      foreach (order[i]) begin
        if (order[i] == id) begin
          order.delete(i);
          break;
        end
      end
      queued[id] = 0;
    endfunction

    function void link(int id);
      int pos;
      pos = 0;
      while (pos < order.size() && dl_of[order[pos]] <= dl_of[id]) pos++;
      order.insert(pos, id);
      queued[id] = 1;
    endfunction

    function void push(logic [1:0] k, int s, logic [TIME_W-1:0] d, bit h);
      word_t w;
      w.kind = k;
      w.slot = s[SLOT_W-1:0];
      w.dl = d;
      w.hit = h;
      w.last = 0;
      pending.push_back(w);
    endfunction

    function void rearm();
      logic [TIME_W-1:0] first;
      first = order.size() ? dl_of[order[0]] : TIME_MAX;
      if (first < armed) begin
        armed = first;
        push(KIND_ARM, 0, first, 0);
      end
    endfunction

    // advance a deadline past now by whole periods, saturating
    function logic [TIME_W-1:0] advance(logic [TIME_W-1:0] d, logic [TIME_W-1:0] now,
                                        logic [TIME_W-1:0] iv);
      logic [TIME_W-1:0] q;
      logic [127:0] add;
      if (d > now) return d;
      if (iv == 0) iv = 1;
      q = (now - d) / iv + 1;
      add = q * {64'd0, iv};
      if (q > TIME_MAX / iv) return TIME_MAX;
      if (add[63:0] > TIME_MAX - d) return TIME_MAX;
      return d + add[63:0];
    endfunction

    function void note_word(logic [1:0] c, int id, logic [TIME_W-1:0] t,
                            logic [TIME_W-1:0] iv);
      int n0;
      int head_id;
      bit hit;
      n0 = pending.size();
      case (c)
        CMD_START: begin
          if (queued[id]) unlink(id);
          dl_of[id] = t;
          link(id);
          rearm();
        end
        CMD_CANCEL: begin
          hit = queued[id];
          if (hit) unlink(id);
          push(KIND_CANCEL, id, 0, hit);
        end
        CMD_EXPIRE: begin
          armed = TIME_MAX;
          while (order.size() > 0 && dl_of[order[0]] <= t) begin
            head_id = order[0];
            unlink(head_id);
            push(KIND_EXPIRED, head_id, 0, 0);
          end
          rearm();
        end
        default: begin
          if (!queued[id]) begin
            dl_of[id] = advance(dl_of[id], t, iv);
            link(id);
            rearm();
          end
        end
      endcase
      if (pending.size() > n0)
        pending[pending.size()-1].last = 1;
    endfunction

    function void check_word(word_t got);
      word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %p", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst = 1;
  logic              start = 0;
  logic              busy;
  logic [1:0]        cmd = CMD_START;
  logic [SLOT_W-1:0] timer_id = '0;
  logic [TIME_W-1:0] time_ns = '0;
  logic [TIME_W-1:0] period_ns = '0;
  logic              strobe;
  logic [1:0]        result_kind;
  logic [SLOT_W-1:0] slot;
  logic [TIME_W-1:0] deadline;
  logic              cancel_hit;
  logic              last;

  timer_scoreboard sb;
  int idle_pct;
  logic [TIME_W-1:0] now_ns;

  deadline_timer_queue DUT (.*);

  always #4 clk = ~clk;

  // check every result word at the edge that accepts it
  always @(posedge clk) begin
    if (!rst && strobe)
      sb.check_word({result_kind, slot, deadline, cancel_hit, last});
  end

  // send one command word and note it once accepted
  task automatic send(logic [1:0] c, int id, logic [TIME_W-1:0] t,
                      logic [TIME_W-1:0] iv);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    cmd <= c;
    timer_id <= id[SLOT_W-1:0];
    time_ns <= t;
    period_ns <= iv;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(c, id, t, iv);
  endtask

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // deadlines near now with frequent ties; sometimes any value
  function automatic logic [TIME_W-1:0] near(logic [TIME_W-1:0] base);
    case ($urandom_range(9))
      0: return rand64();
      1: return base;
      2: return TIME_MAX;
      default: return base + $urandom_range(40);
    endcase
  endfunction

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int id;
    int r;
    sb = new();
    sb.clear();
    idle_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, ties, restarts with zero and huge periods
    send(CMD_EXPIRE, 0, 0, 0);
    send(CMD_CANCEL, 3, 0, 0);
    send(CMD_START, 0, 100, 0);
    send(CMD_START, 1, 100, 0);
    send(CMD_START, 15, TIME_MAX, 0);
    send(CMD_START, 2, 50, 0);
    send(CMD_START, 2, 200, 0);
    send(CMD_RESTART, 0, 0, 0);
    send(CMD_CANCEL, 1, 0, 0);
    send(CMD_CANCEL, 1, 0, 0);
    send(CMD_EXPIRE, 0, 150, 0);
    send(CMD_RESTART, 0, 1000, 0);
    send(CMD_RESTART, 5, TIME_MAX, TIME_MAX);
    send(CMD_RESTART, 6, TIME_MAX - 1, 64'h8000_0000_0000_0000);
    send(CMD_RESTART, 7, 64'h7fff_ffff_ffff_ffff, 3);
    send(CMD_RESTART, 9, TIME_MAX, 0);
    send(CMD_START, 8, 0, 0);
    send(CMD_EXPIRE, 0, TIME_MAX, 0);
    for (int i = 0; i < NT; i++) send(CMD_START, i, 10, 0);
    send(CMD_EXPIRE, 0, 10, 0);

    // random phases: none, sender idle, less idle, none
    now_ns = 1000;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 73 : (ph == 2) ? 23 : 0;
      for (int k = 0; k < 80; k++) begin
        id = $urandom_range(NT - 1);
        r = $urandom_range(99);
        if (r < 45) begin
          send(CMD_START, id, near(now_ns), 0);
        end else if (r < 60) begin
          send(CMD_CANCEL, id, rand64(), rand64());
        end else if (r < 80) begin
          now_ns = now_ns + $urandom_range(30);
          send(CMD_EXPIRE, id, ($urandom_range(19) == 0) ? rand64() : now_ns, rand64());
        end else begin
          send(CMD_RESTART, id, ($urandom_range(9) == 0) ? rand64() : now_ns,
               ($urandom_range(4) == 0) ? rand64() : $urandom_range(20));
        end
      end
    end

    start <= 0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_ram.sv
hw/rtl/dtq_rem.sv
hw/rtl/dtq_cell.sv
hw/rtl/deadline_timer_queue.sv
verif/testbench.sv
